// ----- rtl/adbm_pkg.sv -----
// Package for the ARP/DNS binding monitor: payload structs, protocol
// constants and the controller/datapath command and status structs.
// No dependencies.
package adbm_pkg;

  // Protocol constants
  localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  DNS_RSP_MASK   = 8'h80;
  localparam logic [15:0] DNS_PORT_RESET = 16'd53;

  // Packet class codes
  localparam logic [1:0] CLASS_ARP   = 2'd0;
  localparam logic [1:0] CLASS_DNS   = 2'd1;
  localparam logic [1:0] CLASS_OTHER = 2'd2;

  // Remainder unit: pipeline steps per key
  localparam int unsigned DIV_STEPS = 3;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [15:0] udp_dest_port;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [7:0]  dns_flag_byte;
    logic [31:0] dns_first_word;
    logic [31:0] dns_second_word;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  packet_class;
    logic        arp_poison_alert;
    logic        dns_spoof_alert;
    logic [31:0] alert_address;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;    // clearing pass: write one invalid entry
    logic load;      // capture the accepted packet
    logic div_step;  // one stage of the index remainder
    logic rd_en;     // read both tables at the computed index
    logic res_load;  // decide, update tables, load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // last entry of the clearing pass
    logic mod_fast;  // both table sizes are powers of two
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

// ----- rtl/adbm_if.sv -----
// Valid/ready channel interfaces for the binding monitor: packet input,
// result output and port register write. Depends on adbm_pkg.
interface adbm_pkt_if import adbm_pkg::*; ();
  logic valid;
  logic ready;
  pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface adbm_res_if import adbm_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface adbm_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/adbm_ctrl.sv -----
// Controller of the binding monitor: clearing pass, accept, remainder
// iterations, table read and result hand-off. Depends on adbm_pkg.
module adbm_ctrl import adbm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CMP
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    div_cnt_d  = div_cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          div_cnt_d  = '0;
          state_d    = sts_i.mod_fast ? ST_READ : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        // hold the decision until the output register is free
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

// ----- rtl/adbm_datapath.sv -----
// Datapath of the binding monitor: packet capture, index remainder unit,
// the two binding tables, decision logic and output register.
// Depends on adbm_pkg.
module adbm_datapath import adbm_pkg::*; #(
  parameter int unsigned ARP_ENTRIES = 128,
  parameter int unsigned DNS_ENTRIES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  pkt_t        pkt_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  localparam int unsigned AIW  = $clog2(ARP_ENTRIES);
  localparam int unsigned DIW  = $clog2(DNS_ENTRIES);
  localparam int unsigned MAXN = (ARP_ENTRIES > DNS_ENTRIES) ? ARP_ENTRIES : DNS_ENTRIES;
  localparam int unsigned CW   = $clog2(MAXN);
  localparam bit ARP_POW2 = (ARP_ENTRIES & (ARP_ENTRIES - 1)) == 0;
  localparam bit DNS_POW2 = (DNS_ENTRIES & (DNS_ENTRIES - 1)) == 0;
  localparam logic [AIW:0] ARP_N = (AIW + 1)'(ARP_ENTRIES);
  localparam logic [DIW:0] DNS_N = (DIW + 1)'(DNS_ENTRIES);
  // Reciprocals floor(2^32 / N); the estimated quotient is low by at most one
  localparam logic [63:0] TWO_32 = 64'h1_0000_0000;
  localparam logic [31:0] ARP_M  = 32'(TWO_32 / 64'(ARP_ENTRIES));
  localparam logic [31:0] DNS_M  = 32'(TWO_32 / 64'(DNS_ENTRIES));

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
  } arp_word_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] answer;
  } dns_word_t;

  arp_word_t arp_mem [ARP_ENTRIES];
  dns_word_t dns_mem [DNS_ENTRIES];
  arp_word_t arp_rd_q;
  dns_word_t dns_rd_q;

  logic [15:0]      dns_port_q;
  logic [1:0]       cls_q;
  logic             rsp_q;
  logic [31:0]      key_q;
  logic [47:0]      mac_q;
  logic [31:0]      ans_q;
  logic [63:0]      arp_prod_q, dns_prod_q;
  logic [AIW:0]     arp_r0_q;
  logic [DIW:0]     dns_r0_q;
  logic [AIW-1:0]   arp_rem_q, arp_rem_d;
  logic [DIW-1:0]   dns_rem_q, dns_rem_d;
  logic [CW-1:0]    clr_cnt_q;
  logic             res_valid_q;
  res_t             res_q;

  logic [1:0]     cls_d;
  logic [31:0]    key_d;
  logic [31:0]    arp_qn, dns_qn, arp_diff, dns_diff;
  logic [AIW:0]   arp_fix;
  logic [DIW:0]   dns_fix;
  logic [AIW-1:0] arp_idx, arp_wa;
  logic [DIW-1:0] dns_idx, dns_wa;
  logic           clr_arp, clr_dns, arp_we, dns_we;
  arp_word_t      arp_wd;
  dns_word_t      dns_wd;
  logic           is_arp, is_dns_rsp, poison, spoof;

  // Port register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_port_q <= DNS_PORT_RESET;
    end else if (cfg_valid_i) begin
      dns_port_q <= cfg_data_i;
    end
  end

  // Classification at accept
  always_comb begin
    if (pkt_i.eth_type == ETH_TYPE_ARP) begin
      cls_d = CLASS_ARP;
      key_d = pkt_i.arp_sender_ip;
    end else begin
      key_d = pkt_i.dns_first_word;
      if (pkt_i.eth_type == ETH_TYPE_IPV4 && pkt_i.ip_protocol == PROTO_UDP &&
          pkt_i.udp_dest_port == dns_port_q) begin
        cls_d = CLASS_DNS;
      end else begin
        cls_d = CLASS_OTHER;
      end
    end
  end

  // Remainder unit: reciprocal multiply, multiply-subtract, one correction
  assign arp_qn    = arp_prod_q[63:32] * 32'(ARP_ENTRIES);
  assign dns_qn    = dns_prod_q[63:32] * 32'(DNS_ENTRIES);
  assign arp_diff  = key_q - arp_qn;
  assign dns_diff  = key_q - dns_qn;
  assign arp_fix   = arp_r0_q - ARP_N;
  assign dns_fix   = dns_r0_q - DNS_N;
  assign arp_rem_d = (arp_r0_q >= ARP_N) ? arp_fix[AIW-1:0] : arp_r0_q[AIW-1:0];
  assign dns_rem_d = (dns_r0_q >= DNS_N) ? dns_fix[DIW-1:0] : dns_r0_q[DIW-1:0];

  // Captured packet
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cls_q <= cls_d;
      rsp_q <= (pkt_i.dns_flag_byte & DNS_RSP_MASK) != '0;
      key_q <= key_d;
      mac_q <= pkt_i.arp_sender_mac;
      ans_q <= pkt_i.dns_second_word;
    end
  end

  // Remainder pipeline, one stage per step; valid after the third step
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step) begin
      arp_prod_q <= 64'(key_q) * 64'(ARP_M);
      dns_prod_q <= 64'(key_q) * 64'(DNS_M);
      arp_r0_q   <= arp_diff[AIW:0];
      dns_r0_q   <= dns_diff[DIW:0];
      arp_rem_q  <= arp_rem_d;
      dns_rem_q  <= dns_rem_d;
    end
  end

  assign arp_idx = ARP_POW2 ? key_q[AIW-1:0] : arp_rem_q;
  assign dns_idx = DNS_POW2 ? key_q[DIW-1:0] : dns_rem_q;

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign clr_arp = cmd_i.clr_en && ({1'b0, clr_cnt_q} < (CW + 1)'(ARP_ENTRIES));
  assign clr_dns = cmd_i.clr_en && ({1'b0, clr_cnt_q} < (CW + 1)'(DNS_ENTRIES));

  // Decision on the registered table entries
  assign is_arp     = cls_q == CLASS_ARP;
  assign is_dns_rsp = (cls_q == CLASS_DNS) && rsp_q;
  assign poison     = is_arp && arp_rd_q.valid && (arp_rd_q.ip == key_q) &&
                      (arp_rd_q.mac != mac_q);
  assign spoof      = is_dns_rsp && dns_rd_q.valid && (dns_rd_q.key == key_q) &&
                      (dns_rd_q.answer != ans_q);

  // Table write ports
  always_comb begin
    arp_we = clr_arp || (cmd_i.res_load && is_arp);
    dns_we = clr_dns || (cmd_i.res_load && is_dns_rsp && !spoof);
    if (cmd_i.clr_en) begin
      arp_wa = clr_cnt_q[AIW-1:0];
      dns_wa = clr_cnt_q[DIW-1:0];
      arp_wd = '0;
      dns_wd = '0;
    end else begin
      arp_wa = arp_idx;
      dns_wa = dns_idx;
      arp_wd = '{valid: 1'b1, ip: key_q, mac: mac_q};
      dns_wd = '{valid: 1'b1, key: key_q, answer: ans_q};
    end
  end

  // Binding tables with registered reads
  always_ff @(posedge clk_i) begin
    if (arp_we) begin
      arp_mem[arp_wa] <= arp_wd;
    end
    if (cmd_i.rd_en) begin
      arp_rd_q <= arp_mem[arp_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dns_we) begin
      dns_mem[dns_wa] <= dns_wd;
    end
    if (cmd_i.rd_en) begin
      dns_rd_q <= dns_mem[dns_idx];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.packet_class     <= cls_q;
      res_q.arp_poison_alert <= poison;
      res_q.dns_spoof_alert  <= spoof;
      res_q.alert_address    <= (poison || spoof) ? key_q : '0;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign res_o          = res_q;
  assign sts_o.clr_last = clr_cnt_q == CW'(MAXN - 1);
  assign sts_o.mod_fast = ARP_POW2 && DNS_POW2;
  assign sts_o.out_free = !res_valid_q || res_ready_i;

endmodule

// ----- rtl/arp_dns_binding_monitor.sv -----
// Top level of the ARP/DNS binding monitor: channel interfaces, controller
// and datapath. Depends on adbm_pkg, adbm_if.sv, adbm_ctrl, adbm_datapath.

// Takes one packet's extracted header fields per transaction and returns one
// result: the class (ARP, DNS, other), a poisoning alert when an ARP sender
// IP shows up with a MAC other than the one cached for it, and a spoof alert
// when a DNS response gives a different answer for a cached key; the
// address concerned is reported, zero without alert. Both tables are
// direct-mapped (index = address modulo table size) and overwrite on
// collision. One packet is in work at a time: the index remainder is
// formed by a reciprocal multiply, a multiply-subtract and one correction
// step, then the tables are read and compared and updated; when both table
// sizes are powers of two the remainder is a bit-select instead.
// The result sits in an output register, so the next packet is taken while
// it waits. After reset a clearing pass invalidates every entry of both
// tables before the first packet is accepted; the port register can be
// written at any time and takes effect for packets accepted afterwards.
module arp_dns_binding_monitor import adbm_pkg::*; #(
  parameter int unsigned ARP_ENTRIES = 128,
  parameter int unsigned DNS_ENTRIES = 128
) (
  input logic              clk_i,
  input logic              rst_ni,
  adbm_pkt_if.sink         pkt_i,
  adbm_res_if.source       res_o,
  adbm_cfg_if.sink         cfg_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  adbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pkt_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  adbm_datapath #(
    .ARP_ENTRIES (ARP_ENTRIES),
    .DNS_ENTRIES (DNS_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pkt_i       (pkt_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res_o.data)
  );

  assign pkt_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

`ifndef SYNTHESIS
  // An accepted packet keeps the input closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_i.valid && pkt_i.ready) |=> !pkt_i.ready)
    else $error("input reopened right after an accept");

  // Each alert belongs to its own packet class, never both at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!res_o.data.arp_poison_alert ||
                     res_o.data.packet_class == CLASS_ARP) &&
                    (!res_o.data.dns_spoof_alert ||
                     res_o.data.packet_class == CLASS_DNS))
    else $error("alert does not match packet class");

  // Without an alert the reported address is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.arp_poison_alert && !res_o.data.dns_spoof_alert)
      |-> res_o.data.alert_address == '0)
    else $error("address reported without an alert");
`endif

endmodule
